// File: rtl/dnsd_pkg.sv
// Shared constants, types and codes for the DNS name decompressor.
// Used by the interfaces and every module of the block; depends on nothing.
package dnsd_pkg;

  // Sizing of the message store and the name walk.
  localparam int MSG_BYTES    = 512;
  localparam int MAX_JUMPS    = 20;
  localparam int NAME_MAX     = 255;
  localparam int CHUNK_BYTES  = 8;
  localparam int RESULT_LIMIT = 32;

  // Field widths of the channels.
  localparam int START_W    = 9;
  localparam int CHUNK_OUT  = 64;
  localparam int BYTES_OUT  = 4;
  localparam int CONS_W     = 10;

  // Derived internal widths.
  localparam int ADDR_W  = $clog2(MSG_BYTES);
  localparam int LEN_W   = $clog2(MSG_BYTES + 1);
  localparam int POS_RAW = $clog2(MSG_BYTES + 2);
  localparam int POS_W   = (POS_RAW > START_W) ? POS_RAW : START_W;
  localparam int PTR_W   = 14;
  localparam int CMP_W   = (POS_W > PTR_W) ? POS_W : PTR_W;
  localparam int LBL_W   = 6;
  localparam int JCNT_W  = $clog2(MAX_JUMPS + 1);
  localparam int NLEN_W  = $clog2(NAME_MAX + 1);
  localparam int FILL_W  = $clog2(CHUNK_BYTES + 1);
  localparam int RES_W   = $clog2(RESULT_LIMIT);
  localparam int CHUNK_W = 8 * CHUNK_BYTES;

  // Opcodes of an input transaction.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PARSE = 1'b1;

  // Top two bits of a length byte.
  localparam logic [1:0] TAG_LABEL = 2'b00;
  localparam logic [1:0] TAG_PTR   = 2'b11;

  localparam logic [7:0] CHAR_DOT = 8'h2E;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_OK   = 2'd1,
    ST_BAD  = 2'd2,
    ST_LONG = 2'd3
  } dnsd_status_t;

  // Walker sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_TAG,
    S_TAGD,
    S_PTRD,
    S_LBL,
    S_PUT,
    S_FIN
  } dnsd_state_t;

  // Message store access from the walker.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } dnsd_ram_req_t;

  // Command to the chunk assembler.
  typedef struct packed {
    logic       clr;
    logic       put;
    logic [7:0] ch;
  } dnsd_asm_cmd_t;

  // Response of the chunk assembler.
  typedef struct packed {
    logic               put_long;
    logic               put_emit;
    logic               name_any;
    logic [CHUNK_W-1:0] full_chunk;
    logic [CHUNK_W-1:0] cur_chunk;
    logic [FILL_W-1:0]  cur_fill;
  } dnsd_asm_rsp_t;

  // Result item handed to the output register.
  typedef struct packed {
    logic                 load;
    logic [CHUNK_OUT-1:0] chunk;
    logic [BYTES_OUT-1:0] bytes;
    dnsd_status_t         status;
    logic [CONS_W-1:0]    consumed;
    logic                 last;
  } dnsd_emit_t;

endpackage

// File: rtl/dnsd_if.sv
// Valid/ready channel interfaces for the input and result transactions.
// Depends on dnsd_pkg for the field widths.
interface dnsd_in_if import dnsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [7:0]         data_byte;
  logic [START_W-1:0] start_offset;

  modport source (output valid, opcode, data_byte, start_offset, input ready);
  modport sink   (input valid, opcode, data_byte, start_offset, output ready);
endinterface

interface dnsd_out_if import dnsd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHUNK_OUT-1:0] name_chunk;
  logic [BYTES_OUT-1:0] chunk_bytes;
  logic [1:0]           status;
  logic [CONS_W-1:0]    consumed_length;
  logic                 last_result;

  modport source (output valid, name_chunk, chunk_bytes, status, consumed_length,
                  last_result, input ready);
  modport sink   (input valid, name_chunk, chunk_bytes, status, consumed_length,
                  last_result, output ready);
endinterface

// File: rtl/dnsd_msg_ram.sv
// Message store: single write port, single read port with registered data.
// Depends on dnsd_pkg for depth, address width and the request struct.
module dnsd_msg_ram import dnsd_pkg::*; (
  input  logic          clk,
  input  dnsd_ram_req_t req,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [MSG_BYTES];
  logic [7:0] rd_data_r;

  // Write at the append address.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read data is held until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/dnsd_chunk_asm.sv
// Chunk assembler: packs name characters into chunks and tracks name length
// and the number of chunks sent. Depends on dnsd_pkg.
module dnsd_chunk_asm import dnsd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  dnsd_asm_cmd_t cmd,
  output dnsd_asm_rsp_t rsp
);

  logic [CHUNK_W-1:0] chunk_r;
  logic [FILL_W-1:0]  fill_r;
  logic [NLEN_W-1:0]  name_len_r;
  logic [RES_W-1:0]   res_cnt_r;
  logic [CHUNK_W-1:0] merged;
  logic               full;
  logic               too_long;

  // Insert the character at the fill position and judge the limits.
  always_comb begin
    merged = chunk_r;
    for (int i = 0; i < CHUNK_BYTES; i++) begin
      if (fill_r == FILL_W'(i)) begin
        merged[8*i +: 8] = cmd.ch;
      end
    end
    full     = (fill_r == FILL_W'(CHUNK_BYTES - 1));
    too_long = (name_len_r >= NLEN_W'(NAME_MAX)) ||
               (full && (res_cnt_r >= RES_W'(RESULT_LIMIT - 1)));
  end

  assign rsp.put_long   = too_long;
  assign rsp.put_emit   = full && !too_long;
  assign rsp.name_any   = (name_len_r != '0);
  assign rsp.full_chunk = merged;
  assign rsp.cur_chunk  = chunk_r;
  assign rsp.cur_fill   = fill_r;

  // Assembler registers; a full chunk leaves through the walker.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r    <= '0;
      fill_r     <= '0;
      name_len_r <= '0;
      res_cnt_r  <= '0;
    end else if (cmd.clr) begin
      chunk_r    <= '0;
      fill_r     <= '0;
      name_len_r <= '0;
      res_cnt_r  <= '0;
    end else if (cmd.put && !too_long) begin
      name_len_r <= name_len_r + NLEN_W'(1);
      if (full) begin
        chunk_r   <= '0;
        fill_r    <= '0;
        res_cnt_r <= res_cnt_r + RES_W'(1);
      end else begin
        chunk_r <= merged;
        fill_r  <= fill_r + FILL_W'(1);
      end
    end
  end

endmodule

// File: rtl/dnsd_walker.sv
// Name walker: sequencer that appends message bytes and walks encoded names
// through one shared bounds comparator. Depends on dnsd_pkg.
module dnsd_walker import dnsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [7:0]         in_data_byte,
  input  logic [START_W-1:0] in_start_offset,
  output dnsd_ram_req_t      ram_req,
  input  logic [7:0]         ram_rd_data,
  output dnsd_asm_cmd_t      asm_cmd,
  input  dnsd_asm_rsp_t      asm_rsp,
  input  logic               out_free,
  output dnsd_emit_t         emit
);

  dnsd_state_t       state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic [POS_W-1:0]  resume_r, resume_nxt;
  logic              jumped_r, jumped_nxt;
  logic [JCNT_W-1:0] jcnt_r, jcnt_nxt;
  logic [LBL_W-1:0]  cnt_r, cnt_nxt;
  logic [LBL_W-1:0]  hi_r, hi_nxt;
  logic              dot_r, dot_nxt;
  dnsd_status_t      fin_r, fin_nxt;

  logic [POS_W-1:0]  pos_inc1;
  logic [POS_W-1:0]  pos_inc2;
  logic [JCNT_W-1:0] jcnt_inc;
  logic [PTR_W-1:0]  ptr;
  logic [CMP_W-1:0]  cmp_op;
  logic              in_bounds;

  assign pos_inc1  = pos_r + POS_W'(1);
  assign pos_inc2  = pos_r + POS_W'(2);
  assign jcnt_inc  = jcnt_r + JCNT_W'(1);
  assign ptr       = {hi_r, ram_rd_data};

  // Shared bounds comparator: every position check goes through here.
  assign in_bounds = (cmp_op < CMP_W'(len_r));

  // State and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      len_r    <= '0;
      pos_r    <= '0;
      start_r  <= '0;
      resume_r <= '0;
      jumped_r <= 1'b0;
      jcnt_r   <= '0;
      cnt_r    <= '0;
      hi_r     <= '0;
      dot_r    <= 1'b0;
      fin_r    <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      resume_r <= resume_nxt;
      jumped_r <= jumped_nxt;
      jcnt_r   <= jcnt_nxt;
      cnt_r    <= cnt_nxt;
      hi_r     <= hi_nxt;
      dot_r    <= dot_nxt;
      fin_r    <= fin_nxt;
    end
  end

  // Sequencer: next state, datapath controls and result items.
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    resume_nxt = resume_r;
    jumped_nxt = jumped_r;
    jcnt_nxt   = jcnt_r;
    cnt_nxt    = cnt_r;
    hi_nxt     = hi_r;
    dot_nxt    = dot_r;
    fin_nxt    = fin_r;

    in_ready        = 1'b0;
    cmp_op          = CMP_W'(pos_r);
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = len_r[ADDR_W-1:0];
    ram_req.wr_data = in_data_byte;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = pos_r[ADDR_W-1:0];
    asm_cmd.clr     = 1'b0;
    asm_cmd.put     = 1'b0;
    asm_cmd.ch      = dot_r ? CHAR_DOT : ram_rd_data;
    emit.load       = 1'b0;
    emit.chunk      = '0;
    emit.bytes      = '0;
    emit.status     = ST_MORE;
    emit.consumed   = '0;
    emit.last       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_PARSE) begin
            pos_nxt     = POS_W'(in_start_offset);
            start_nxt   = POS_W'(in_start_offset);
            resume_nxt  = '0;
            jumped_nxt  = 1'b0;
            jcnt_nxt    = '0;
            asm_cmd.clr = 1'b1;
            state_nxt   = S_TAG;
          end else if (len_r < LEN_W'(MSG_BYTES)) begin
            ram_req.wr_en = 1'b1;
            len_nxt       = len_r + LEN_W'(1);
          end
        end
      end

      // Check the position and read a length or pointer byte.
      S_TAG: begin
        if (!in_bounds) begin
          fin_nxt   = ST_BAD;
          state_nxt = S_FIN;
        end else begin
          ram_req.rd_en = 1'b1;
          state_nxt     = S_TAGD;
        end
      end

      // Decode the length byte.
      S_TAGD: begin
        cmp_op = CMP_W'(pos_inc1);
        if (ram_rd_data == '0) begin
          if (!jumped_r) begin
            resume_nxt = pos_inc1;
          end
          fin_nxt   = ST_OK;
          state_nxt = S_FIN;
        end else if (ram_rd_data[7:6] == TAG_PTR) begin
          if (!in_bounds) begin
            fin_nxt   = ST_BAD;
            state_nxt = S_FIN;
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = pos_inc1[ADDR_W-1:0];
            hi_nxt          = ram_rd_data[LBL_W-1:0];
            state_nxt       = S_PTRD;
          end
        end else if (ram_rd_data[7:6] != TAG_LABEL) begin
          fin_nxt   = ST_BAD;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = ram_rd_data[LBL_W-1:0];
          pos_nxt = pos_inc1;
          if (asm_rsp.name_any) begin
            dot_nxt   = 1'b1;
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_LBL;
          end
        end
      end

      // Follow a compression pointer.
      S_PTRD: begin
        cmp_op = CMP_W'(ptr);
        if (!in_bounds) begin
          fin_nxt   = ST_BAD;
          state_nxt = S_FIN;
        end else begin
          if (!jumped_r) begin
            resume_nxt = pos_inc2;
            jumped_nxt = 1'b1;
          end
          jcnt_nxt = jcnt_inc;
          if (jcnt_inc >= JCNT_W'(MAX_JUMPS)) begin
            fin_nxt   = ST_BAD;
            state_nxt = S_FIN;
          end else begin
            pos_nxt   = POS_W'(ptr);
            state_nxt = S_TAG;
          end
        end
      end

      // Read the next label character, or go back for the next label.
      S_LBL: begin
        if (cnt_r == '0) begin
          state_nxt = S_TAG;
        end else if (!in_bounds) begin
          fin_nxt   = ST_BAD;
          state_nxt = S_FIN;
        end else begin
          ram_req.rd_en = 1'b1;
          dot_nxt       = 1'b0;
          state_nxt     = S_PUT;
        end
      end

      // Add one character; a chunk that fills leaves at once.
      S_PUT: begin
        if (out_free) begin
          asm_cmd.put = 1'b1;
          if (asm_rsp.put_long) begin
            fin_nxt   = ST_LONG;
            state_nxt = S_FIN;
          end else begin
            if (asm_rsp.put_emit) begin
              emit.load  = 1'b1;
              emit.chunk = CHUNK_OUT'(asm_rsp.full_chunk);
              emit.bytes = BYTES_OUT'(CHUNK_BYTES);
            end
            if (!dot_r) begin
              pos_nxt = pos_inc1;
              cnt_nxt = cnt_r - LBL_W'(1);
            end
            state_nxt = S_LBL;
          end
        end
      end

      // Final result item, then the message is cleared.
      S_FIN: begin
        if (out_free) begin
          emit.load   = 1'b1;
          emit.status = fin_r;
          emit.last   = 1'b1;
          if (fin_r == ST_OK) begin
            emit.chunk    = CHUNK_OUT'(asm_rsp.cur_chunk);
            emit.bytes    = BYTES_OUT'(asm_rsp.cur_fill);
            emit.consumed = CONS_W'(resume_r - start_r);
          end
          len_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/dns_name_decompressor.sv
// Top level of the DNS name decompressor: walker, chunk assembler, message
// store and the result register. Depends on dnsd_pkg, dnsd_if and the submodules.
//
//   Channel  Direction  Handshake      Payload
//   in_ch    sink       valid/ready    opcode, data_byte, start_offset
//   out_ch   source     valid/ready    name_chunk, chunk_bytes, status,
//                                      consumed_length, last_result
//
// An append writes one byte at the message end. A parse is accepted, then each
// length byte or terminator takes a bounds check with read and a decode, a pointer
// adds a read and the jump, a name character a bounds check with read and a put, a
// dot a put, a label end and the final item a step each; the single read port of
// the store with its registered data sets this pace. Input is not ready during a
// parse. A stalled result register holds the walker at its next character or final
// item. Reset is synchronous and active low; no clearing pass is needed.
module dns_name_decompressor import dnsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dnsd_in_if.sink    in_ch,
  dnsd_out_if.source out_ch
);

  dnsd_ram_req_t ram_req;
  logic [7:0]    ram_rd_data;
  dnsd_asm_cmd_t asm_cmd;
  dnsd_asm_rsp_t asm_rsp;
  dnsd_emit_t    emit;
  logic          out_free;

  logic                 out_valid_r;
  logic [CHUNK_OUT-1:0] out_chunk_r;
  logic [BYTES_OUT-1:0] out_bytes_r;
  dnsd_status_t         out_status_r;
  logic [CONS_W-1:0]    out_cons_r;
  logic                 out_last_r;

  dnsd_walker u_walker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_opcode       (in_ch.opcode),
    .in_data_byte    (in_ch.data_byte),
    .in_start_offset (in_ch.start_offset),
    .ram_req         (ram_req),
    .ram_rd_data     (ram_rd_data),
    .asm_cmd         (asm_cmd),
    .asm_rsp         (asm_rsp),
    .out_free        (out_free),
    .emit            (emit)
  );

  dnsd_chunk_asm u_chunk_asm (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (asm_cmd),
    .rsp   (asm_rsp)
  );

  dnsd_msg_ram u_msg_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  // Result register: free when empty or when its transaction completes.
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_chunk_r  <= emit.chunk;
      out_bytes_r  <= emit.bytes;
      out_status_r <= emit.status;
      out_cons_r   <= emit.consumed;
      out_last_r   <= emit.last;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.name_chunk      = out_chunk_r;
  assign out_ch.chunk_bytes     = out_bytes_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.consumed_length = out_cons_r;
  assign out_ch.last_result     = out_last_r;

  // A final item never says more follows.
  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_result |-> out_ch.status != ST_MORE)
    else $error("final result item carries the more-follows status");

  // An intermediate item is always a full chunk.
  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last_result |->
      out_ch.chunk_bytes == BYTES_OUT'(CHUNK_BYTES) && out_ch.status == ST_MORE)
    else $error("intermediate result item is not a full chunk");

  // Only a successful parse reports a consumed length.
  a_cons_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.consumed_length == '0)
    else $error("consumed length reported without success");

  // A parse transaction makes the input busy on the next cycle.
  a_parse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.opcode == OP_PARSE |=> !in_ch.ready)
    else $error("input ready right after a parse transaction");

endmodule
